### rtl/mvsf_pkg.sv
// Shared types and constants for the memory value search filter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package mvsf_pkg;

	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int COUNT_W = 17;
	localparam int MODE_W  = 3;

	// The pass counter saturates at this value.
	localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h10000;

	// Search operation carried by each transaction.
	typedef enum logic [MODE_W-1:0] {
		MODE_SNAPSHOT  = 3'd0,
		MODE_UNCHANGED = 3'd1,
		MODE_CHANGED   = 3'd2,
		MODE_DECREASED = 3'd3,
		MODE_INCREASED = 3'd4,
		MODE_EXCLUDE   = 3'd5
	} mode_t;

	// One word of the candidate store: the candidate flag and the last stored byte.
	typedef struct packed {
		logic              cand;
		logic [DATA_W-1:0] value;
	} entry_t;

	// Write port of the candidate store.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            entry;
	} wr_t;

	// One queued result.
	typedef struct packed {
		logic [ADDR_W-1:0]  out_address;
		logic               still_candidate;
		logic [COUNT_W-1:0] match_count;
		logic               out_last;
	} res_t;

endpackage

### rtl/mvsf_search_if.sv
// Handshake channel that carries search items into the filter.
// Depends on mvsf_pkg for the field widths.
interface mvsf_search_if;
	logic                          valid;
	logic                          ready;
	logic [mvsf_pkg::MODE_W-1:0]   mode;
	logic [mvsf_pkg::ADDR_W-1:0]   address;
	logic [mvsf_pkg::DATA_W-1:0]   data_value;
	logic                          pass_end;

	modport source (output valid, mode, address, data_value, pass_end, input ready);
	modport sink (input valid, mode, address, data_value, pass_end, output ready);
endinterface

### rtl/mvsf_result_if.sv
// Handshake channel that carries filter results out of the block.
// Depends on mvsf_pkg for the field widths.
interface mvsf_result_if;
	logic                          valid;
	logic                          ready;
	logic [mvsf_pkg::ADDR_W-1:0]   out_address;
	logic                          still_candidate;
	logic [mvsf_pkg::COUNT_W-1:0]  match_count;
	logic                          out_last;

	modport source (output valid, out_address, still_candidate, match_count, out_last,
		input ready);
	modport sink (input valid, out_address, still_candidate, match_count, out_last,
		output ready);
endinterface

### rtl/mvsf_store.sv
// Candidate store: one synchronous memory of {flag, byte} words with a registered read.
// After reset it sweeps every word to zero, one per cycle. Depends on mvsf_pkg.
module mvsf_store #(
	parameter int DEPTH = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [mvsf_pkg::ADDR_W-1:0] rd_addr,
	output mvsf_pkg::entry_t            rd_entry,
	input  mvsf_pkg::wr_t               wr,
	output logic                        busy
);

	localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mvsf_pkg::entry_t mem [DEPTH];
	mvsf_pkg::entry_t rd_entry_q;
	logic             clr_active_q;
	logic [IdxW-1:0]  clr_idx_q;

	// Clearing sweep after reset, one word per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_idx_q == IdxW'(DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// Memory array: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr[IdxW-1:0]] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr[IdxW-1:0]];
		end
	end

	assign rd_entry = rd_entry_q;
	assign busy     = clr_active_q;

endmodule

### rtl/memory_value_search_filter.sv
// Memory value search filter. One search transaction is taken per clock cycle while search
// ready is high, and each one gives exactly one result through the stage-one registers and
// the result queue. The candidate flags and stored bytes share one memory of
// min(MEM_DEPTH, 65536) words with a registered read; the second stage compares, updates
// the pass counter and writes the word back, and a one-entry forwarding register covers a
// back-to-back transaction to the same address. After reset the block clears that memory
// one word per cycle, and the search channel stays not ready until the clear is done. A
// three-entry result queue lets the block keep accepting while a result waits to be taken.
// Depends on mvsf_pkg, the two channel interfaces and mvsf_store.
module memory_value_search_filter #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mvsf_search_if.sink          search,
	mvsf_result_if.source        result
);

	localparam int StoreDepth = (MEM_DEPTH < 65536) ? MEM_DEPTH : 65536;

	// Stage-one registers: the transaction whose memory word is being read.
	logic                          valid_s1;
	logic [mvsf_pkg::MODE_W-1:0]   mode_s1;
	logic [mvsf_pkg::ADDR_W-1:0]   addr_s1;
	logic [mvsf_pkg::DATA_W-1:0]   data_s1;
	logic                          last_s1;
	logic                          range_s1;

	logic                          accept;
	logic                          store_busy;
	mvsf_pkg::entry_t              rd_entry;
	mvsf_pkg::wr_t                 wr;
	mvsf_pkg::wr_t                 byp_q;
	mvsf_pkg::entry_t              old_entry;
	mvsf_pkg::entry_t              new_entry;
	logic                          hit;
	logic [mvsf_pkg::COUNT_W-1:0]  count_q;
	logic [mvsf_pkg::COUNT_W-1:0]  count_now;
	mvsf_pkg::res_t                res_s1;

	// Result queue.
	mvsf_pkg::res_t                q_mem [3];
	logic [1:0]                    q_head_q;
	logic [1:0]                    q_tail_q;
	logic [1:0]                    q_cnt_q;
	logic                          q_pop;

	assign accept       = search.valid && search.ready;
	assign search.ready = !store_busy && ((3'(q_cnt_q) + 3'(valid_s1)) < 3'd3);

	mvsf_store #(
		.DEPTH(StoreDepth)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (search.address),
		.rd_entry(rd_entry),
		.wr      (wr),
		.busy    (store_busy)
	);

	// Stage one capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= search.mode;
			addr_s1  <= search.address;
			data_s1  <= search.data_value;
			last_s1  <= search.pass_end;
			range_s1 <= 32'(search.address) < 32'(MEM_DEPTH);
		end
	end

	// The write of the previous cycle is not yet visible in the read data; forward it.
	always_comb begin
		if (byp_q.en && (byp_q.addr == addr_s1)) begin
			old_entry = byp_q.entry;
		end else begin
			old_entry = rd_entry;
		end
	end

	// Compare and update the entry.
	always_comb begin
		new_entry = old_entry;
		hit       = 1'b0;
		unique case (mvsf_pkg::mode_t'(mode_s1))
			mvsf_pkg::MODE_SNAPSHOT: begin
				new_entry.cand  = 1'b1;
				new_entry.value = data_s1;
			end
			mvsf_pkg::MODE_EXCLUDE: begin
				new_entry.cand = 1'b0;
			end
			mvsf_pkg::MODE_UNCHANGED: begin
				hit = old_entry.cand && (data_s1 == old_entry.value);
			end
			mvsf_pkg::MODE_CHANGED: begin
				hit = old_entry.cand && (data_s1 != old_entry.value);
			end
			mvsf_pkg::MODE_DECREASED: begin
				hit = old_entry.cand && (data_s1 < old_entry.value);
			end
			mvsf_pkg::MODE_INCREASED: begin
				hit = old_entry.cand && (data_s1 > old_entry.value);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		// Compare modes drop a candidate on a miss and store the byte on a hit.
		if ((mode_s1 == mvsf_pkg::MODE_UNCHANGED) || (mode_s1 == mvsf_pkg::MODE_CHANGED) ||
			(mode_s1 == mvsf_pkg::MODE_DECREASED) || (mode_s1 == mvsf_pkg::MODE_INCREASED)) begin
			if (hit) begin
				new_entry.value = data_s1;
			end else begin
				new_entry.cand = 1'b0;
			end
		end
		if (!range_s1) begin
			hit = 1'b0;
		end
	end

	// Write-back and forwarding register.
	always_comb begin
		wr.en    = valid_s1 && range_s1;
		wr.addr  = addr_s1;
		wr.entry = new_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= '0;
		end else begin
			byp_q <= wr;
		end
	end

	// Pass counter, saturating, cleared after the last transaction of a pass.
	assign count_now = (hit && (count_q != mvsf_pkg::COUNT_MAX)) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (valid_s1) begin
			count_q <= last_s1 ? '0 : count_now;
		end
	end

	always_comb begin
		res_s1.out_address     = addr_s1;
		res_s1.still_candidate = range_s1 && new_entry.cand;
		res_s1.match_count     = count_now;
		res_s1.out_last        = last_s1;
	end

	// Result queue control.
	assign q_pop = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q <= '0;
			q_tail_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (valid_s1) begin
				q_tail_q <= (q_tail_q == 2'd2) ? 2'd0 : q_tail_q + 1'b1;
			end
			if (q_pop) begin
				q_head_q <= (q_head_q == 2'd2) ? 2'd0 : q_head_q + 1'b1;
			end
			q_cnt_q <= q_cnt_q + 2'(valid_s1) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			q_mem[q_tail_q] <= res_s1;
		end
	end

	assign result.valid           = q_cnt_q != 2'd0;
	assign result.out_address     = q_mem[q_head_q].out_address;
	assign result.still_candidate = q_mem[q_head_q].still_candidate;
	assign result.match_count     = q_mem[q_head_q].match_count;
	assign result.out_last        = q_mem[q_head_q].out_last;

endmodule

### verif/memory_value_search_filter_tb.sv
// Self-checking testbench for memory_value_search_filter: a directed table and random
// search passes, each result checked against a local predictor or, for typed rows, the table.
// Depends on mvsf_pkg, mvsf_search_if, mvsf_result_if and the filter RTL.
`timescale 1ns / 1ps

module memory_value_search_filter_tb;

	localparam int MEM_SPAN = 65536;
	localparam int N_DIRECTED = 23;
	localparam int MAX_REPORTS = 30;

	// Unused operation codes that the mode field can still carry.
	localparam logic [mvsf_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [mvsf_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

	typedef struct {
		logic [mvsf_pkg::MODE_W-1:0] mode;
		logic [mvsf_pkg::ADDR_W-1:0] address;
		logic [mvsf_pkg::DATA_W-1:0] data_value;
		logic                        pass_end;
	} search_item_t;

	// One stimulus row; typed rows carry a result that is known at a glance.
	typedef struct {
		search_item_t                 item;
		bit                           typed;
		logic                         still;
		logic [mvsf_pkg::COUNT_W-1:0] count;
	} directed_row_t;

	logic clk;
	logic arst_n;

	mvsf_search_if search_ch ();
	mvsf_result_if result_ch ();

	memory_value_search_filter #(.MEM_DEPTH(MEM_SPAN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.search(search_ch),
		.result(result_ch)
	);

	// Mirror of the candidate store and the pass counter.
	bit                           cand_mirror [MEM_SPAN];
	logic [mvsf_pkg::DATA_W-1:0]  byte_mirror [MEM_SPAN];
	logic [mvsf_pkg::COUNT_W-1:0] pass_count_mirror = '0;

	mvsf_pkg::res_t pending_results [$];
	int   n_errors = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   long_stall_len = 0;

	directed_row_t directed_rows [N_DIRECTED];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Applies one transaction to the mirror and returns the result the filter must give.
	function automatic mvsf_pkg::res_t predict_search_result(input search_item_t it);
		mvsf_pkg::res_t r;
		logic hit;
		hit = 1'b0;
		if (int'(it.address) < MEM_SPAN) begin
			case (it.mode)
				mvsf_pkg::MODE_SNAPSHOT: begin
					cand_mirror[it.address] = 1'b1;
					byte_mirror[it.address] = it.data_value;
				end
				mvsf_pkg::MODE_EXCLUDE: cand_mirror[it.address] = 1'b0;
				mvsf_pkg::MODE_UNCHANGED, mvsf_pkg::MODE_CHANGED, mvsf_pkg::MODE_DECREASED,
				mvsf_pkg::MODE_INCREASED: begin
					if (cand_mirror[it.address]) begin
						case (it.mode)
							mvsf_pkg::MODE_UNCHANGED:
								hit = (it.data_value == byte_mirror[it.address]);
							mvsf_pkg::MODE_CHANGED:
								hit = (it.data_value != byte_mirror[it.address]);
							mvsf_pkg::MODE_DECREASED:
								hit = (it.data_value < byte_mirror[it.address]);
							default:
								hit = (it.data_value > byte_mirror[it.address]);
						endcase
						if (hit) begin
							byte_mirror[it.address] = it.data_value;
							if (pass_count_mirror < mvsf_pkg::COUNT_MAX)
								pass_count_mirror = pass_count_mirror + 1'b1;
						end else begin
							cand_mirror[it.address] = 1'b0;
						end
					end
				end
				default: ;
			endcase
			r.still_candidate = cand_mirror[it.address];
		end else begin
			r.still_candidate = 1'b0;
		end
		r.out_address = it.address;
		r.match_count = pass_count_mirror;
		r.out_last = it.pass_end;
		if (it.pass_end)
			pass_count_mirror = '0;
		return r;
	endfunction

	function automatic search_item_t mk_item(input logic [mvsf_pkg::MODE_W-1:0] m,
		input logic [mvsf_pkg::ADDR_W-1:0] a, input logic [mvsf_pkg::DATA_W-1:0] d,
		input logic l);
		search_item_t it;
		it.mode = m;
		it.address = a;
		it.data_value = d;
		it.pass_end = l;
		return it;
	endfunction

	function automatic directed_row_t drow(input logic [mvsf_pkg::MODE_W-1:0] m,
		input logic [mvsf_pkg::ADDR_W-1:0] a, input logic [mvsf_pkg::DATA_W-1:0] d,
		input logic l, input bit typed, input logic still,
		input logic [mvsf_pkg::COUNT_W-1:0] count);
		directed_row_t r;
		r.item = mk_item(m, a, d, l);
		r.typed = typed;
		r.still = still;
		r.count = count;
		return r;
	endfunction

	// Probe bytes land on, just above or just below the stored byte most of the time.
	function automatic logic [mvsf_pkg::DATA_W-1:0] pick_probe_value(
		input logic [mvsf_pkg::ADDR_W-1:0] a);
		logic [mvsf_pkg::DATA_W-1:0] s;
		s = byte_mirror[a];
		if (!cand_mirror[a])
			return mvsf_pkg::DATA_W'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: return s;
			1: return s + 1'b1;
			2: return s - 1'b1;
			default: return mvsf_pkg::DATA_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Offers one transaction, waits for it to be taken and records its expected result.
	task automatic send_item(input search_item_t it, input bit typed, input logic still,
		input logic [mvsf_pkg::COUNT_W-1:0] count);
		mvsf_pkg::res_t want;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			search_ch.valid <= 1'b0;
			@(posedge clk);
		end
		search_ch.valid <= 1'b1;
		search_ch.mode <= it.mode;
		search_ch.address <= it.address;
		search_ch.data_value <= it.data_value;
		search_ch.pass_end <= it.pass_end;
		@(posedge clk);
		while (!search_ch.ready)
			@(posedge clk);
		want = predict_search_result(it);
		if (typed) begin
			want.still_candidate = still;
			want.match_count = count;
		end
		pending_results.push_back(want);
	endtask

	// Random search passes: snapshot a pool of addresses, then compare rounds over it,
	// with stray transactions and exclusions mixed in. Whole passes are sent until the
	// number of transactions reaches the target.
	task automatic run_search_passes(input int target);
		logic [mvsf_pkg::ADDR_W-1:0] pool [16];
		logic [mvsf_pkg::MODE_W-1:0] round_mode;
		logic [mvsf_pkg::MODE_W-1:0] m;
		search_item_t it;
		int pool_n;
		int rounds;
		int counted;
		counted = 0;
		while (counted < target) begin
			pool_n = $urandom_range(2, 16);
			for (int i = 0; i < pool_n; i++)
				pool[i] = mvsf_pkg::ADDR_W'($urandom_range(0, 65535));
			rounds = $urandom_range(1, 5);
			for (int r = 0; r <= rounds; r++) begin
				round_mode = (r == 0) ? mvsf_pkg::MODE_SNAPSHOT :
					mvsf_pkg::MODE_W'($urandom_range(1, 4));
				for (int i = 0; i < pool_n; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						it = mk_item(mvsf_pkg::MODE_W'($urandom_range(0, 7)),
							mvsf_pkg::ADDR_W'($urandom_range(0, 65535)),
							mvsf_pkg::DATA_W'($urandom_range(0, 255)),
							$urandom_range(0, 7) == 0);
						counted++;
						send_item(it, 1'b0, 1'b0, '0);
					end
					m = ($urandom_range(0, 19) == 0) ? mvsf_pkg::MODE_EXCLUDE : round_mode;
					it = mk_item(m, pool[i], pick_probe_value(pool[i]),
						i == pool_n - 1 && $urandom_range(0, 3) != 0);
					counted++;
					send_item(it, 1'b0, 1'b0, '0);
				end
			end
		end
	endtask

	// Result side: check each transaction against the oldest expectation, then decide
	// whether to stall the next cycle.
	initial begin : result_sink
		int stall_left;
		bit stall_taken;
		mvsf_pkg::res_t want;
		stall_left = 0;
		stall_taken = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (pending_results.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: unexpected result addr=%h cand=%b count=%0d last=%b",
							$time, result_ch.out_address, result_ch.still_candidate,
							result_ch.match_count, result_ch.out_last);
				end else begin
					want = pending_results.pop_front();
					if (result_ch.out_address !== want.out_address ||
						result_ch.still_candidate !== want.still_candidate ||
						result_ch.match_count !== want.match_count ||
						result_ch.out_last !== want.out_last) begin
						n_errors++;
						if (n_errors <= MAX_REPORTS)
							$display("%0t: mismatch expected addr=%h cand=%b count=%0d last=%b,",
								$time, want.out_address, want.still_candidate,
								want.match_count, want.out_last,
								" got addr=%h cand=%b count=%0d last=%b",
								result_ch.out_address, result_ch.still_candidate,
								result_ch.match_count, result_ch.out_last);
					end
				end
			end
			if (long_stall_len != 0 && !stall_taken) begin
				stall_left = long_stall_len;
				stall_taken = 1'b1;
			end
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		search_ch.valid = 1'b0;
		search_ch.mode = mvsf_pkg::MODE_SNAPSHOT;
		search_ch.address = '0;
		search_ch.data_value = '0;
		search_ch.pass_end = 1'b0;

		// Directed table: extremes, every operation, back-to-back updates of one address,
		// spare codes, exclusion and pass boundaries.
		directed_rows[0]  = drow(mvsf_pkg::MODE_UNCHANGED, 16'h0000, 8'h00, 1'b0,
			1'b1, 1'b0, 17'd0);
		directed_rows[1]  = drow(MODE_SPARE7, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 1'b0, 17'd0);
		directed_rows[2]  = drow(mvsf_pkg::MODE_SNAPSHOT, 16'h0000, 8'h00, 1'b0,
			1'b1, 1'b1, 17'd0);
		directed_rows[3]  = drow(mvsf_pkg::MODE_SNAPSHOT, 16'hFFFF, 8'hFF, 1'b0,
			1'b1, 1'b1, 17'd0);
		directed_rows[4]  = drow(mvsf_pkg::MODE_UNCHANGED, 16'h0000, 8'h00, 1'b0,
			1'b1, 1'b1, 17'd1);
		directed_rows[5]  = drow(mvsf_pkg::MODE_INCREASED, 16'hFFFF, 8'hFF, 1'b0,
			1'b1, 1'b0, 17'd1);
		directed_rows[6]  = drow(mvsf_pkg::MODE_SNAPSHOT, 16'h1234, 8'h80, 1'b0,
			1'b1, 1'b1, 17'd1);
		directed_rows[7]  = drow(mvsf_pkg::MODE_DECREASED, 16'h1234, 8'h7F, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[8]  = drow(mvsf_pkg::MODE_INCREASED, 16'h1234, 8'h80, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[9]  = drow(mvsf_pkg::MODE_CHANGED, 16'h1234, 8'h80, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[10] = drow(mvsf_pkg::MODE_DECREASED, 16'h1234, 8'h00, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[11] = drow(mvsf_pkg::MODE_SNAPSHOT, 16'hA5A5, 8'h5A, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[12] = drow(mvsf_pkg::MODE_CHANGED, 16'hA5A5, 8'hA5, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[13] = drow(MODE_SPARE6, 16'hA5A5, 8'h00, 1'b0, 1'b0, 1'b0, '0);
		directed_rows[14] = drow(mvsf_pkg::MODE_EXCLUDE, 16'hA5A5, 8'h00, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[15] = drow(mvsf_pkg::MODE_UNCHANGED, 16'hA5A5, 8'h5A, 1'b1,
			1'b0, 1'b0, '0);
		directed_rows[16] = drow(mvsf_pkg::MODE_SNAPSHOT, 16'h5A5A, 8'hFF, 1'b0,
			1'b1, 1'b1, 17'd0);
		directed_rows[17] = drow(mvsf_pkg::MODE_DECREASED, 16'h5A5A, 8'h00, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[18] = drow(mvsf_pkg::MODE_INCREASED, 16'h5A5A, 8'hFF, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[19] = drow(mvsf_pkg::MODE_EXCLUDE, 16'h0001, 8'h00, 1'b1,
			1'b0, 1'b0, '0);
		directed_rows[20] = drow(mvsf_pkg::MODE_SNAPSHOT, 16'h0000, 8'hFF, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[21] = drow(mvsf_pkg::MODE_DECREASED, 16'h0000, 8'hFE, 1'b0,
			1'b0, 1'b0, '0);
		directed_rows[22] = drow(mvsf_pkg::MODE_INCREASED, 16'h0000, 8'hFE, 1'b1,
			1'b0, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// The search channel stays not ready while the store is cleared after reset.
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].still,
				directed_rows[i].count);

		// Random passes under each idling mix.
		run_search_passes(100);
		tx_idle_pct = 69;
		run_search_passes(100);
		tx_idle_pct = 0;
		rx_stall_pct <= 69;
		run_search_passes(100);
		tx_idle_pct = 26;
		rx_stall_pct <= 26;
		run_search_passes(100);

		// Long receiver hold-off while the sender keeps offering, so the input backs up.
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		long_stall_len <= 60;
		run_search_passes(50);

		// Sender pause until the filter has drained.
		search_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
		tx_idle_pct = 26;
		rx_stall_pct <= 26;
		run_search_passes(100);
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		run_search_passes(100);

		search_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("memory_value_search_filter_tb: clean");
		else
			$display("memory_value_search_filter_tb: errors");
		$finish;
	end

	// Run limit, far above the store clear and the random part.
	initial begin
		#10_000_000;
		$display("memory_value_search_filter_tb: errors");
		$finish;
	end

endmodule
